// File: src/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement unit.
`timescale 1ns / 1ps

package lrupr_pkg;

    // Fixed field widths of the ports.
    localparam int unsigned PAGE_PORT_W   = 16;
    localparam int unsigned FRAME_PORT_W  = 3;
    localparam int unsigned FAULT_W       = 32;
    localparam int unsigned CFG_W         = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

    // Search record flags that travel along the chain of frame cells.
    typedef struct packed {
        logic go;
        logic found;
        logic has_empty;
        logic has_victim;
    } t_probe;

    // Update command broadcast to every cell at the end of a reference.
    typedef struct packed {
        logic apply;
        logic fill;
        logic clear;
        logic hit;
    } t_commit;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

// File: src/lrupr_cell.sv
// One page frame: holds page, valid bit and age rank, and forwards the search record.
`timescale 1ns / 1ps

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned IDX_W    = 3,
    parameter int unsigned RANK_W   = 3,
    parameter int unsigned PAGE_W   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Broadcast from the sequencer
    input  logic              i_active,
    input  logic [PAGE_W-1:0] i_page,
    input  t_commit           i_commit,
    input  logic [IDX_W-1:0]  i_commit_frame,
    input  logic [RANK_W-1:0] i_commit_limit,
    // Search record from the previous cell
    input  t_probe            i_probe,
    input  logic [IDX_W-1:0]  i_found_idx,
    input  logic [RANK_W-1:0] i_found_rank,
    input  logic [IDX_W-1:0]  i_empty_idx,
    input  logic [IDX_W-1:0]  i_victim_idx,
    input  logic [RANK_W-1:0] i_victim_rank,
    input  logic [PAGE_W-1:0] i_victim_page,
    // Search record to the next cell
    output t_probe            o_probe,
    output logic [IDX_W-1:0]  o_found_idx,
    output logic [RANK_W-1:0] o_found_rank,
    output logic [IDX_W-1:0]  o_empty_idx,
    output logic [IDX_W-1:0]  o_victim_idx,
    output logic [RANK_W-1:0] o_victim_rank,
    output logic [PAGE_W-1:0] o_victim_page
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic [PAGE_W-1:0] r_page;

    t_probe            r_probe;
    logic [IDX_W-1:0]  r_found_idx;
    logic [RANK_W-1:0] r_found_rank;
    logic [IDX_W-1:0]  r_empty_idx;
    logic [IDX_W-1:0]  r_victim_idx;
    logic [RANK_W-1:0] r_victim_rank;
    logic [PAGE_W-1:0] r_victim_page;

    t_probe            n_probe;
    logic [IDX_W-1:0]  n_found_idx;
    logic [RANK_W-1:0] n_found_rank;
    logic [IDX_W-1:0]  n_empty_idx;
    logic [IDX_W-1:0]  n_victim_idx;
    logic [RANK_W-1:0] n_victim_rank;
    logic [PAGE_W-1:0] n_victim_page;

    logic w_is_me;

    assign w_is_me = (i_commit_frame == MY_IDX);

    // Fold this frame into the search record: first match, first empty, oldest frame.
    always_comb begin
        n_probe       = i_probe;
        n_found_idx   = i_found_idx;
        n_found_rank  = i_found_rank;
        n_empty_idx   = i_empty_idx;
        n_victim_idx  = i_victim_idx;
        n_victim_rank = i_victim_rank;
        n_victim_page = i_victim_page;
        if (i_active && r_valid) begin
            if (!i_probe.found && (r_page == i_page)) begin
                n_probe.found = 1'b1;
                n_found_idx   = MY_IDX;
                n_found_rank  = r_rank;
            end
            if (!i_probe.has_victim || (r_rank > i_victim_rank)) begin
                n_probe.has_victim = 1'b1;
                n_victim_idx       = MY_IDX;
                n_victim_rank      = r_rank;
                n_victim_page      = r_page;
            end
        end else if (i_active && !i_probe.has_empty) begin
            n_probe.has_empty = 1'b1;
            n_empty_idx       = MY_IDX;
        end
    end

    // Search record register; data holds after the record has passed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else if (i_probe.go) begin
            r_probe <= n_probe;
        end else begin
            r_probe.go <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_probe.go) begin
            r_found_idx   <= n_found_idx;
            r_found_rank  <= n_found_rank;
            r_empty_idx   <= n_empty_idx;
            r_victim_idx  <= n_victim_idx;
            r_victim_rank <= n_victim_rank;
            r_victim_page <= n_victim_page;
        end
    end

    // Frame state update: the chosen frame becomes youngest, younger frames age by one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_commit.apply) begin
            if (i_commit.clear) begin
                r_valid <= 1'b0;
                r_rank  <= '0;
            end else if (w_is_me) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && (i_commit.fill || (r_rank < i_commit_limit))) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    // Page store is written only when a new page is brought in.
    always_ff @(posedge i_clk) begin
        if (i_commit.apply && !i_commit.clear && !i_commit.hit && w_is_me) begin
            r_page <= i_page;
        end
    end

    assign o_probe       = r_probe;
    assign o_found_idx   = r_found_idx;
    assign o_found_rank  = r_found_rank;
    assign o_empty_idx   = r_empty_idx;
    assign o_victim_idx  = r_victim_idx;
    assign o_victim_rank = r_victim_rank;
    assign o_victim_page = r_victim_page;

endmodule

// File: src/lru_page_replacement_unit.sv
// Top level: sequencer, fault counter and chain of frame cells.
// A transfer sets the start register; the search record then walks the chain of frame cells
// one cell per cycle, and the decision loads the output register once that register is free.
// No new reference is taken until the decision for the previous one is made.
// A new reference is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties all frames, clears the fault count and sets
// the frame count register to 8.
`timescale 1ns / 1ps

module lru_page_replacement_unit
    import lrupr_pkg::*;
#(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // Reference input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [PAGE_PORT_W-1:0]  i_page_number,
    input  logic                    i_last_reference,
    // Result output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic [FRAME_PORT_W-1:0] o_frame_index,
    output logic                    o_evicted_valid,
    output logic [PAGE_PORT_W-1:0]  o_evicted_page,
    output logic [FAULT_W-1:0]      o_fault_count
);

    localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned RANK_W = IDX_W;
    localparam int unsigned PAGE_W = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]   r_frames_in_use;
    logic [PAGE_W-1:0]  r_page;
    logic               r_last;
    logic               r_start;
    logic               n_start;
    logic [FAULT_W-1:0] r_fault_total;
    logic [FAULT_W-1:0] n_fault_total;

    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [FRAME_PORT_W-1:0] r_out_frame;
    logic                    r_out_ev_valid;
    logic [PAGE_PORT_W-1:0]  r_out_ev_page;
    logic [FAULT_W-1:0]      r_out_fault;

    logic w_in_ready;
    logic w_out_free;
    logic w_commit_go;

    // Chain wiring: entry 0 feeds the first cell, entry FRAMES leaves the last one.
    t_probe            w_probe       [FRAMES+1];
    logic [IDX_W-1:0]  w_found_idx   [FRAMES+1];
    logic [RANK_W-1:0] w_found_rank  [FRAMES+1];
    logic [IDX_W-1:0]  w_empty_idx   [FRAMES+1];
    logic [IDX_W-1:0]  w_victim_idx  [FRAMES+1];
    logic [RANK_W-1:0] w_victim_rank [FRAMES+1];
    logic [PAGE_W-1:0] w_victim_page [FRAMES+1];
    logic [FRAMES-1:0] w_active;
    logic [FRAMES:0]   w_go_vec;

    t_commit                   w_commit;
    logic [IDX_W-1:0]          w_frame;
    logic [RANK_W-1:0]         w_limit;
    logic [IDX_W+FRAME_PORT_W-1:0] w_frame_ext;
    t_probe                    w_result;

    // Configuration register; the write channel is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    // Active frames: frame 0 always, others below the configured count.
    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_active
            assign w_active[g] = (g == 0) || (32'(r_frames_in_use) > g);
        end
    endgenerate

    // Head of the chain: an empty search record launched in the cycle after the transfer.
    assign w_probe[0]       = '{go: r_start, found: 1'b0, has_empty: 1'b0, has_victim: 1'b0};
    assign w_found_idx[0]   = '0;
    assign w_found_rank[0]  = '0;
    assign w_empty_idx[0]   = '0;
    assign w_victim_idx[0]  = '0;
    assign w_victim_rank[0] = '0;
    assign w_victim_page[0] = '0;
    assign w_go_vec[0]      = r_start;

    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            lrupr_cell #(
                .CELL_IDX (g),
                .IDX_W    (IDX_W),
                .RANK_W   (RANK_W),
                .PAGE_W   (PAGE_W)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_active       (w_active[g]),
                .i_page         (r_page),
                .i_commit       (w_commit),
                .i_commit_frame (w_frame),
                .i_commit_limit (w_limit),
                .i_probe        (w_probe[g]),
                .i_found_idx    (w_found_idx[g]),
                .i_found_rank   (w_found_rank[g]),
                .i_empty_idx    (w_empty_idx[g]),
                .i_victim_idx   (w_victim_idx[g]),
                .i_victim_rank  (w_victim_rank[g]),
                .i_victim_page  (w_victim_page[g]),
                .o_probe        (w_probe[g+1]),
                .o_found_idx    (w_found_idx[g+1]),
                .o_found_rank   (w_found_rank[g+1]),
                .o_empty_idx    (w_empty_idx[g+1]),
                .o_victim_idx   (w_victim_idx[g+1]),
                .o_victim_rank  (w_victim_rank[g+1]),
                .o_victim_page  (w_victim_page[g+1])
            );
            assign w_go_vec[g+1] = w_probe[g+1].go;
        end
    endgenerate

    // Decision from the finished search record, which the last cell holds.
    assign w_result = w_probe[FRAMES];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (w_result.found) begin
            w_frame = w_found_idx[FRAMES];
        end else if (w_result.has_empty) begin
            w_frame = w_empty_idx[FRAMES];
        end else begin
            w_frame = w_victim_idx[FRAMES];
        end
        w_limit = w_result.found ? w_found_rank[FRAMES] : w_victim_rank[FRAMES];
    end

    assign w_frame_ext = {{FRAME_PORT_W{1'b0}}, w_frame};

    assign w_commit = '{apply: w_commit_go,
                        fill:  !w_result.found && w_result.has_empty,
                        clear: r_last,
                        hit:   w_result.found};

    // Saturating fault count including this reference.
    always_comb begin
        n_fault_total = r_fault_total;
        if (!w_result.found && (r_fault_total != FAULT_MAX)) begin
            n_fault_total = r_fault_total + FAULT_W'(1);
        end
    end

    // Sequencer: next state and handshake controls.
    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        n_start     = 1'b0;
        w_commit_go = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_result.go) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    w_commit_go = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // Capture of the reference on its transfer.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_page <= i_page_number[PAGE_W-1:0];
            r_last <= i_last_reference;
        end
    end

    // Fault counter; the last reference of a sequence clears it after its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_total <= '0;
        end else if (w_commit_go) begin
            r_fault_total <= r_last ? '0 : n_fault_total;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit_go) begin
            r_out_hit      <= w_result.found;
            r_out_frame    <= w_frame_ext[FRAME_PORT_W-1:0];
            r_out_ev_valid <= !w_result.found && !w_result.has_empty;
            r_out_ev_page  <= (!w_result.found && !w_result.has_empty) ?
                              PAGE_PORT_W'(w_victim_page[FRAMES]) : '0;
            r_out_fault    <= n_fault_total;
        end
    end

    assign o_in_ready      = w_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_frame;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_count   = r_out_fault;

    // At most one search record is in flight along the chain.
    a_single_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_go_vec))
        else $error("more than one search record in the chain");

    // A new reference is taken only when no search is in flight.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_go_vec == '0))
        else $error("reference taken while a search is in flight");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit reported together with an eviction");

    // Without an eviction the evicted page reads as zero.
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page not zero without an eviction");

    // A decision loads the output register and raises the result valid.
    a_commit_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit_go |=> o_out_valid)
        else $error("decision did not load the output register");

endmodule

// File: tb/lru_result_checker.sv
// Checker for the LRU page replacement unit: predicts each reference's result and compares.
`timescale 1ns / 1ps

module lru_result_checker
    import lrupr_pkg::*;
#(
    parameter int unsigned FRAMES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [PAGE_PORT_W-1:0]  i_page_number,
    input  logic                    i_last_reference,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_hit,
    input  logic [FRAME_PORT_W-1:0] i_frame_index,
    input  logic                    i_evicted_valid,
    input  logic [PAGE_PORT_W-1:0]  i_evicted_page,
    input  logic [FAULT_W-1:0]      i_fault_count,
    output int                      o_outstanding,
    output int                      o_mismatches
);

    typedef struct packed {
        logic                    hit;
        logic [FRAME_PORT_W-1:0] frame;
        logic                    evicted;
        logic [PAGE_PORT_W-1:0]  evicted_page;
        logic [FAULT_W-1:0]      faults;
    } t_ref_result;

    // Shadow copy of the frame table, the fault count and the frame count register.
    logic [PAGE_PORT_W-1:0] frame_page [FRAMES];
    logic                   frame_used [FRAMES];
    int unsigned            frame_age  [FRAMES];
    logic [FAULT_W-1:0]     seq_faults;
    logic [CFG_W-1:0]       frame_limit;

    t_ref_result pending_results [$];
    int          mismatch_total = 0;

    // Empty every frame and restart the fault count.
    function automatic void empty_all_frames();
        for (int k = 0; k < FRAMES; k++) begin
            frame_page[k] = '0;
            frame_used[k] = 1'b0;
            frame_age[k]  = 0;
        end
        seq_faults = '0;
    endfunction

    // Frame f becomes the newest; valid frames younger than the limit grow one step older.
    function automatic void make_newest(int f, int unsigned limit);
        for (int k = 0; k < FRAMES; k++) begin
            if (k != f && frame_used[k] && frame_age[k] < limit) begin
                frame_age[k] = frame_age[k] + 1;
            end
        end
        frame_age[f] = 0;
    endfunction

    // Look the page up among the active frames, update recency and work out the result.
    function automatic t_ref_result predict_reference(logic [PAGE_PORT_W-1:0] page,
                                                      logic last_ref);
        t_ref_result r;
        int          active;
        int          found;
        int          empty;
        int          victim;
        int          frame;
        r      = '0;
        found  = -1;
        empty  = -1;
        victim = -1;
        if (frame_limit == 0) begin
            active = 1;
        end else if (frame_limit > FRAMES) begin
            active = FRAMES;
        end else begin
            active = frame_limit;
        end

        for (int k = 0; k < active; k++) begin
            if (frame_used[k]) begin
                if (found < 0 && frame_page[k] == page) begin
                    found = k;
                end
                if (victim < 0 || frame_age[k] > frame_age[victim]) begin
                    victim = k;
                end
            end else if (empty < 0) begin
                empty = k;
            end
        end

        if (found >= 0) begin
            frame = found;
            r.hit = 1'b1;
            make_newest(frame, frame_age[frame]);
        end else begin
            if (empty >= 0) begin
                frame             = empty;
                frame_used[frame] = 1'b1;
                frame_page[frame] = page;
                make_newest(frame, 32'hFFFF);
            end else begin
                frame             = victim;
                r.evicted         = 1'b1;
                r.evicted_page    = frame_page[frame];
                frame_page[frame] = page;
                make_newest(frame, frame_age[frame]);
            end
            if (seq_faults != FAULT_MAX) begin
                seq_faults = seq_faults + 1'b1;
            end
        end

        r.frame  = frame[FRAME_PORT_W-1:0];
        r.faults = seq_faults;
        if (last_ref) begin
            empty_all_frames();
        end
        return r;
    endfunction

    // Count a mismatch and describe the first few of them.
    task automatic report_mismatch(string cause, t_ref_result seen, t_ref_result want);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("[%0t] %s (expected/actual): hit %0b/%0b frame %0d/%0d",
                     $realtime, cause, want.hit, seen.hit, want.frame, seen.frame);
            $display("    evicted %0b/%0b page %h/%h faults %0d/%0d",
                     want.evicted, seen.evicted, want.evicted_page, seen.evicted_page,
                     want.faults, seen.faults);
        end
    endtask

    // Follow every transfer on the three channels.
    always @(posedge i_clk) begin
        t_ref_result seen;
        t_ref_result want;
        if (!i_rst_n) begin
            empty_all_frames();
            frame_limit = CFG_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                frame_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                seen = '{i_hit, i_frame_index, i_evicted_valid, i_evicted_page, i_fault_count};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no reference waiting", seen, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        report_mismatch("result mismatch", seen, want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(predict_reference(i_page_number, i_last_reference));
            end
        end
        o_outstanding <= pending_results.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

// File: tb/testbench.sv
// Testbench top for the LRU page replacement unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import lrupr_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned SEGMENTS = 30;
    localparam int unsigned SEGMENT_REFS = 50;
    localparam int unsigned HOT_MAX = 12;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [PAGE_PORT_W-1:0]  in_page = '0;
    logic                    in_last = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    out_hit;
    logic [FRAME_PORT_W-1:0] out_frame;
    logic                    out_evicted;
    logic [PAGE_PORT_W-1:0]  out_evicted_page;
    logic [FAULT_W-1:0]      out_faults;

    int outstanding;
    int mismatches;
    int idle_pct = 0;
    int stall_pct = 0;
    int unsigned cycle_count = 0;

    logic [PAGE_PORT_W-1:0] hot_pages [HOT_MAX];

    // Free-running clock, 12 ns period.
    always #6 clk = ~clk;

    lru_page_replacement_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_page_number    (in_page),
        .i_last_reference (in_last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_hit            (out_hit),
        .o_frame_index    (out_frame),
        .o_evicted_valid  (out_evicted),
        .o_evicted_page   (out_evicted_page),
        .o_fault_count    (out_faults)
    );

    lru_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_page_number    (in_page),
        .i_last_reference (in_last),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_hit            (out_hit),
        .i_frame_index    (out_frame),
        .i_evicted_valid  (out_evicted),
        .i_evicted_page   (out_evicted_page),
        .i_fault_count    (out_faults),
        .o_outstanding    (outstanding),
        .o_mismatches     (mismatches)
    );

    // The result side stalls at random according to the current stall rate.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Give up if the run takes far longer than any correct one could.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one reference, possibly after an idle gap, and wait for its transfer.
    task automatic send_reference(input logic [PAGE_PORT_W-1:0] page, input logic last_ref);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_page  <= page;
        in_last  <= last_ref;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold the sender until every result is back, then write the frame count register.
    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned hot_count;
        logic [PAGE_PORT_W-1:0] page;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: fill all frames, evict, hit, then shrink and grow the active set.
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);
        for (int p = 1; p <= 6; p++) begin
            send_reference(PAGE_PORT_W'(p), 1'b0);
        end
        send_reference(16'h8000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);

        // A page left in an inactive frame is loaded again, so it becomes resident twice.
        write_frame_count(4'd2);
        send_reference(16'h0005, 1'b0);
        send_reference(16'h0005, 1'b0);
        write_frame_count(4'd8);
        send_reference(16'h0005, 1'b0);

        // A frame count of zero acts as one; counts above eight act as eight.
        write_frame_count(4'd0);
        send_reference(16'h0007, 1'b0);
        send_reference(16'h0007, 1'b0);
        write_frame_count(4'd15);
        send_reference(16'h5555, 1'b0);
        send_reference(16'hAAAA, 1'b1);
        send_reference(16'hAAAA, 1'b0);
        write_frame_count(4'd1);
        send_reference(16'h0003, 1'b0);
        send_reference(16'h0004, 1'b1);

        // Random part: short sequences over a small set of hot pages, with some stray pages.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg % 3 != 2) begin
                case ($urandom_range(5))
                    0: write_frame_count(4'd0);
                    1: write_frame_count(4'd1);
                    2: write_frame_count(4'd8);
                    3: write_frame_count(4'd15);
                    default: write_frame_count(CFG_W'($urandom_range(15)));
                endcase
            end
            case (seg % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  = 73;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct <= 73;
                end
                default: begin
                    idle_pct  = 12;
                    stall_pct <= 12;
                end
            endcase
            hot_count = $urandom_range(1, HOT_MAX);
            for (int h = 0; h < HOT_MAX; h++) begin
                hot_pages[h] = PAGE_PORT_W'($urandom);
            end
            for (int n = 0; n < SEGMENT_REFS; n++) begin
                if ($urandom_range(99) < 85) begin
                    page = hot_pages[$urandom_range(hot_count - 1)];
                end else begin
                    page = PAGE_PORT_W'($urandom);
                end
                send_reference(page, $urandom_range(39) == 0);
            end
        end

        // Wait for the last results, let the block settle, then give the verdict.
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
